>>> sv/lcd_scanline_mode_timer_defines.svh
// Assertion helpers shared by the scanline timer RTL.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef LCD_SCANLINE_MODE_TIMER_DEFINES_SVH
`define LCD_SCANLINE_MODE_TIMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LST_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lst_pkg.sv
`timescale 1ns / 1ps

package lst_pkg;

    localparam int unsigned DOT_W  = 10;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned SUM_W  = DOT_W + 1;

    localparam logic [DOT_W-1:0]  OAM_END      = 10'd80;
    localparam logic [DOT_W-1:0]  TRANSFER_END = 10'd248;
    localparam logic [LINE_W-1:0] LAST_LINE    = 8'd153;

    localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

    // Timer state carried from one word to the next.
    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [LINE_W-1:0] line;
        logic [MODE_W-1:0] mode;
        logic              match;
    } lst_state_t;

    // One result word before packing onto the output bus.
    typedef struct packed {
        logic              frame_clear;
        logic              draw_request;
        logic              vblank_request;
        logic              coincidence;
        logic [MODE_W-1:0] display_mode;
        logic [LINE_W-1:0] line_number;
    } lst_result_t;

endpackage

>>> sv/lcd_scanline_mode_timer.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while m_tready is high. A word accepted on s_* goes via the input
// and output registers to m_*; the state update is a single add, compare and subtract.
// An input register and an output register decouple the two sides, so input is taken
// while a finished result waits. Reset (rst_n low, asynchronous) clears the dot counter,
// line and coincidence flag, sets the mode to OAM search and compare_line to zero.

`include "lcd_scanline_mode_timer_defines.svh"

module lcd_scanline_mode_timer #(
    parameter int unsigned LINE_CYCLES   = 456,
    parameter int unsigned VISIBLE_LINES = 144
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: compare_line.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] clock_delta

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] line_number, [9:8] display_mode, [10] coincidence,
    // [11] vblank_request, [12] draw_request, [13] frame_clear, [15:14] zero
    output logic [15:0] m_tdata
);

    // Input stage: one word of elapsed clocks waiting to be applied.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_data_reg;

    // Output stage: the result of the last applied word.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    lst_pkg::lst_result_t out_data_reg;

    // Timer state and the compare register.
    lst_pkg::lst_state_t         state_reg;
    lst_pkg::lst_state_t         state_next;
    lst_pkg::lst_result_t        step_result;
    logic [lst_pkg::LINE_W-1:0]  compare_reg;

    logic advance;

    // The state is updated exactly when a word moves from the input register into the
    // output register, so each step sees the state left by the step before it.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    lst_step #(
        .LINE_CYCLES   (LINE_CYCLES),
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_step (
        .state_cur    (state_reg),
        .elapsed      (in_data_reg),
        .compare_line (compare_reg),
        .state_nxt    (state_next),
        .result       (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
            in_valid_next = 1'b0;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.dot   <= '0;
            state_reg.line  <= '0;
            state_reg.mode  <= lst_pkg::MODE_OAM;
            state_reg.match <= 1'b0;
            compare_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                compare_reg <= cfg_data;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (advance)
            out_data_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.frame_clear,
                       out_data_reg.draw_request,
                       out_data_reg.vblank_request,
                       out_data_reg.coincidence,
                       out_data_reg.display_mode,
                       out_data_reg.line_number};

    // The dot counter never reaches a full line and the line never passes the last one.
    `LST_ASSERT_SAME(a_state_range,
        1'b1,
        (state_reg.dot < lst_pkg::DOT_W'(LINE_CYCLES)) && (state_reg.line <= lst_pkg::LAST_LINE),
        "timer state out of range")

    // A frame-clear result always shows line zero in vertical blank.
    `LST_ASSERT_SAME(a_clear_wrap,
        m_tvalid && m_tdata[13],
        (m_tdata[7:0] == 8'd0) && (m_tdata[9:8] == lst_pkg::MODE_VBLANK),
        "frame clear without wrap to line zero")

    // A draw request only comes with a visible line, never in vertical blank.
    `LST_ASSERT_SAME(a_draw_visible,
        m_tvalid && m_tdata[12],
        (m_tdata[9:8] != lst_pkg::MODE_VBLANK) && (m_tdata[7:0] != 8'd0),
        "draw request outside the visible lines")

    // Each applied word produces a result in the next cycle.
    `LST_ASSERT_NEXT(a_advance_result,
        advance,
        out_valid_reg,
        "applied word produced no result")

endmodule

>>> sv/lst_step.sv
`timescale 1ns / 1ps

// Combinational update of the timer state for one word of elapsed clocks.
module lst_step #(
    parameter int unsigned LINE_CYCLES   = 456,
    parameter int unsigned VISIBLE_LINES = 144
) (
    input  lst_pkg::lst_state_t             state_cur,
    input  logic [7:0]                      elapsed,
    input  logic [lst_pkg::LINE_W-1:0]      compare_line,
    output lst_pkg::lst_state_t             state_nxt,
    output lst_pkg::lst_result_t            result
);

    localparam logic [lst_pkg::SUM_W-1:0]  LineLen = lst_pkg::SUM_W'(LINE_CYCLES);
    localparam logic [lst_pkg::LINE_W-1:0] VisEnd  = lst_pkg::LINE_W'(VISIBLE_LINES);

    logic [lst_pkg::SUM_W-1:0]  sum;
    logic [lst_pkg::LINE_W-1:0] line;
    logic [lst_pkg::MODE_W-1:0] mode;
    logic                       match;
    logic                       draw;
    logic                       vblank;
    logic                       clear;

    always_comb
    begin
        sum    = {1'b0, state_cur.dot} + {{(lst_pkg::SUM_W - 8){1'b0}}, elapsed};
        line   = state_cur.line;
        mode   = state_cur.mode;
        match  = state_cur.match;
        draw   = 1'b0;
        vblank = 1'b0;
        clear  = 1'b0;

        // The remainder is always below one line length, so one subtract suffices.
        if (sum >= LineLen)
        begin
            sum   = sum - LineLen;
            line  = line + 8'd1;
            match = (line == compare_line);
            draw  = (line < VisEnd);
        end

        if (line < VisEnd)
        begin
            priority if (sum[lst_pkg::DOT_W-1:0] < lst_pkg::OAM_END)
                mode = lst_pkg::MODE_OAM;
            else if (sum[lst_pkg::DOT_W-1:0] < lst_pkg::TRANSFER_END)
                mode = lst_pkg::MODE_TRANSFER;
            else
                mode = lst_pkg::MODE_HBLANK;
        end
        else
        begin
            if (mode != lst_pkg::MODE_VBLANK)
            begin
                mode   = lst_pkg::MODE_VBLANK;
                vblank = 1'b1;
            end
            // The line went one past the last one: wrap to the top of the frame.
            if (line > lst_pkg::LAST_LINE)
            begin
                line  = '0;
                clear = 1'b1;
            end
        end

        state_nxt.dot   = sum[lst_pkg::DOT_W-1:0];
        state_nxt.line  = line;
        state_nxt.mode  = mode;
        state_nxt.match = match;

        result.line_number    = line;
        result.display_mode   = mode;
        result.coincidence    = match;
        result.vblank_request = vblank;
        result.draw_request   = draw;
        result.frame_clear    = clear;
    end

endmodule
